FILE: hw/rtl/amm_pkg.sv
// Audio mixing matrix: shared types, widths and codes.
// No dependencies; compiled first.
`default_nettype none

package amm_pkg;

  localparam int CH_MAX     = 8;
  localparam int CH_IDX_W   = 3;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int HALF_W     = PROD_W + 2;   // sum of four products
  localparam int ACC_W      = PROD_W + 3;   // sum of eight products
  localparam int FRAC_SHIFT = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_GAIN  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_ENABLE  = 4'd0,
    REG_OUTPUT_ENABLE = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
    logic signed [SAMPLE_W-1:0] sample_4;
    logic signed [SAMPLE_W-1:0] sample_5;
    logic signed [SAMPLE_W-1:0] sample_6;
    logic signed [SAMPLE_W-1:0] sample_7;
    logic [CH_IDX_W-1:0]        gain_source;
    logic [CH_IDX_W-1:0]        gain_target;
    logic signed [GAIN_W-1:0]   gain_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_0;
    logic signed [SAMPLE_W-1:0] mixed_1;
    logic signed [SAMPLE_W-1:0] mixed_2;
    logic signed [SAMPLE_W-1:0] mixed_3;
    logic signed [SAMPLE_W-1:0] mixed_4;
    logic signed [SAMPLE_W-1:0] mixed_5;
    logic signed [SAMPLE_W-1:0] mixed_6;
    logic signed [SAMPLE_W-1:0] mixed_7;
    logic [CH_MAX-1:0]          clipped;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  // gain table write port
  typedef struct packed {
    logic                     en;
    logic [CH_IDX_W-1:0]      src;
    logic [CH_IDX_W-1:0]      dst;
    logic signed [GAIN_W-1:0] value;
  } gain_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/amm_stream_if.sv
// Valid/ready channel carrying one payload of type T.
// Used with the payload types of amm_pkg.
`default_nettype none

interface amm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/amm_gain_table.sv
// Gain table of the mixing matrix: one flop per gain, all read in parallel.
// Depends on amm_pkg.
`default_nettype none

module amm_gain_table import amm_pkg::*; #(
  parameter int INPUT_CHANNELS  = 8,
  parameter int OUTPUT_CHANNELS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gain_wr_t                 wr_i,
  output logic signed [GAIN_W-1:0]      gain_o [INPUT_CHANNELS][OUTPUT_CHANNELS]
);

  logic signed [GAIN_W-1:0] gain_q [INPUT_CHANNELS][OUTPUT_CHANNELS];

  // out-of-range source or target matches no entry, so the write drops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
        for (int j = 0; j < OUTPUT_CHANNELS; j++) begin
          gain_q[i][j] <= '0;
        end
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
        for (int j = 0; j < OUTPUT_CHANNELS; j++) begin
          if (wr_i.src == CH_IDX_W'(i) && wr_i.dst == CH_IDX_W'(j)) begin
            gain_q[i][j] <= wr_i.value;
          end
        end
      end
    end
  end

  assign gain_o = gain_q;

endmodule

`default_nettype wire

FILE: hw/rtl/audio_mixing_matrix_core.sv
// Audio mixing matrix core: 8x8 fixed-point gain matrix mixer, four stages.
// Depends on amm_pkg, amm_stream_if and amm_gain_table.
`default_nettype none

//  Channel   | Dir | Payload     | Transfer
//  ----------+-----+-------------+-------------------------------------------
//  cfg_i     | in  | cfg_wr_t    | register write (0 input_enable, 1 output_enable)
//  item_i    | in  | in_item_t   | frame of samples, or one gain write
//  result_o  | out | out_item_t  | mixed frame, one per input frame
//
//  One item per clock sustained while result_o is ready. A frame reaches result_o
//  through its stages in order: input register, 64 parallel 16x16 multipliers,
//  two 4-input adder trees per output, then final add, floor shift and saturation.
//  A gain write retires in the first stage and gives no result; it updates
//  the table there, so frames before it see the old gain and frames after
//  it the new one. Reset clears the gain table flops at once.
//  Each stage holds while the next one is full and stalled; empty stages
//  fill up, so item_i keeps taking transfers while a result waits, until all are full.

module audio_mixing_matrix_core import amm_pkg::*; #(
  parameter int INPUT_CHANNELS  = 8,
  parameter int OUTPUT_CHANNELS = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  amm_stream_if.sink    cfg_i,
  amm_stream_if.sink    item_i,
  amm_stream_if.source  result_o
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sd32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sd32768);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CH_MAX-1:0] in_en_q;
  logic [CH_MAX-1:0] out_en_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_en_q  <= '1;
      out_en_q <= '1;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.index == REG_INPUT_ENABLE) begin
        in_en_q <= cfg_i.data.value;
      end
      if (cfg_i.data.index == REG_OUTPUT_ENABLE) begin
        out_en_q <= cfg_i.data.value;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage handshakes
  // ---------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_kind_q;
  logic s2_ready, s3_ready, out_ready;
  logic s1_frame;

  assign s1_frame     = s1_valid_q && (s1_kind_q == KIND_FRAME);
  assign out_ready    = !out_valid_q || result_o.ready;
  assign s3_ready     = !s3_valid_q || out_ready;
  assign s2_ready     = !s2_valid_q || s3_ready;
  // a gain write leaves stage 1 without needing room downstream
  assign item_i.ready = !s1_valid_q || (s1_kind_q == KIND_GAIN) || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_frame;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register, disabled inputs zeroed
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] item_sample [CH_MAX];
  logic signed [SAMPLE_W-1:0] s1_sample_q [INPUT_CHANNELS];
  logic [CH_IDX_W-1:0]        s1_src_q, s1_dst_q;
  logic signed [GAIN_W-1:0]   s1_gain_q;

  assign item_sample[0] = item_i.data.sample_0;
  assign item_sample[1] = item_i.data.sample_1;
  assign item_sample[2] = item_i.data.sample_2;
  assign item_sample[3] = item_i.data.sample_3;
  assign item_sample[4] = item_i.data.sample_4;
  assign item_sample[5] = item_i.data.sample_5;
  assign item_sample[6] = item_i.data.sample_6;
  assign item_sample[7] = item_i.data.sample_7;

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_kind_q <= item_i.data.kind;
      s1_src_q  <= item_i.data.gain_source;
      s1_dst_q  <= item_i.data.gain_target;
      s1_gain_q <= item_i.data.gain_value;
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
        s1_sample_q[i] <= in_en_q[i] ? item_sample[i] : '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Gain table, written by a gain item as it sits in stage 1
  // ---------------------------------------------------------------------
  gain_wr_t                 gain_wr;
  logic signed [GAIN_W-1:0] gain [INPUT_CHANNELS][OUTPUT_CHANNELS];

  assign gain_wr.en    = s1_valid_q && (s1_kind_q == KIND_GAIN);
  assign gain_wr.src   = s1_src_q;
  assign gain_wr.dst   = s1_dst_q;
  assign gain_wr.value = s1_gain_q;

  amm_gain_table #(
    .INPUT_CHANNELS  (INPUT_CHANNELS),
    .OUTPUT_CHANNELS (OUTPUT_CHANNELS)
  ) u_gain_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (gain_wr),
    .gain_o (gain)
  );

  // ---------------------------------------------------------------------
  // Stage 2: one product per matrix cell
  // ---------------------------------------------------------------------
  logic signed [PROD_W-1:0] s2_prod_q [INPUT_CHANNELS][OUTPUT_CHANNELS];

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_frame) begin
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
        for (int j = 0; j < OUTPUT_CHANNELS; j++) begin
          s2_prod_q[i][j] <= s1_sample_q[i] * gain[i][j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: two partial sums per output (inputs 0-3 and 4-7)
  // ---------------------------------------------------------------------
  logic signed [HALF_W-1:0] half_lo [OUTPUT_CHANNELS];
  logic signed [HALF_W-1:0] half_hi [OUTPUT_CHANNELS];
  logic signed [HALF_W-1:0] s3_lo_q [OUTPUT_CHANNELS];
  logic signed [HALF_W-1:0] s3_hi_q [OUTPUT_CHANNELS];

  always_comb begin
    for (int j = 0; j < OUTPUT_CHANNELS; j++) begin
      half_lo[j] = '0;
      half_hi[j] = '0;
      for (int i = 0; i < INPUT_CHANNELS; i++) begin
        if (i < 4) begin
          half_lo[j] = half_lo[j] + HALF_W'(s2_prod_q[i][j]);
        end else begin
          half_hi[j] = half_hi[j] + HALF_W'(s2_prod_q[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_lo_q <= half_lo;
      s3_hi_q <= half_hi;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: final add, floor shift, saturate, output mask
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] mixed_d [CH_MAX];
  logic [CH_MAX-1:0]          clip_d;
  logic signed [SAMPLE_W-1:0] mixed_q [CH_MAX];
  logic [CH_MAX-1:0]          clip_q;

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    acc     = '0;
    shifted = '0;
    clip_d  = '0;
    for (int j = 0; j < CH_MAX; j++) begin
      mixed_d[j] = '0;
    end
    for (int j = 0; j < OUTPUT_CHANNELS; j++) begin
      acc     = ACC_W'(s3_lo_q[j]) + ACC_W'(s3_hi_q[j]);
      shifted = acc >>> FRAC_SHIFT;
      if (out_en_q[j]) begin
        if (shifted > SAT_MAX) begin
          mixed_d[j] = SAT_MAX[SAMPLE_W-1:0];
          clip_d[j]  = 1'b1;
        end else if (shifted < SAT_MIN) begin
          mixed_d[j] = SAT_MIN[SAMPLE_W-1:0];
          clip_d[j]  = 1'b1;
        end else begin
          mixed_d[j] = shifted[SAMPLE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s3_valid_q) begin
      mixed_q <= mixed_d;
      clip_q  <= clip_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.data.mixed_0 = mixed_q[0];
  assign result_o.data.mixed_1 = mixed_q[1];
  assign result_o.data.mixed_2 = mixed_q[2];
  assign result_o.data.mixed_3 = mixed_q[3];
  assign result_o.data.mixed_4 = mixed_q[4];
  assign result_o.data.mixed_5 = mixed_q[5];
  assign result_o.data.mixed_6 = mixed_q[6];
  assign result_o.data.mixed_7 = mixed_q[7];
  assign result_o.data.clipped = clip_q;

endmodule

`default_nettype wire
